>>> rtl/assert_macros.svh
// Assertion macros used by the key click and hold detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that b holds in the same cycle whenever a holds.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
// Check that b holds in the cycle after a holds.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> rtl/kchd_pkg.sv
// Shared types and constants of the key click and hold detector.
package kchd_pkg;

  localparam int unsigned NumKeys  = 8;
  localparam int unsigned KeyW     = 3;
  localparam int unsigned KeyIdxW  = (NumKeys > 1) ? $clog2(NumKeys) : 1;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CntW     = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [CntW-1:0] ClickMax = 4'd15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_LONG_PRESS  = 3'd1,
    REG_CLICK_GAP   = 3'd2,
    REG_HOLD_START  = 3'd3,
    REG_HOLD_REPEAT = 3'd4
  } reg_idx_e;

  localparam logic [CfgW-1:0] DebounceRst   = 16'd50;
  localparam logic [CfgW-1:0] LongPressRst  = 16'd1000;
  localparam logic [CfgW-1:0] ClickGapRst   = 16'd300;
  localparam logic [CfgW-1:0] HoldStartRst  = 16'd500;
  localparam logic [CfgW-1:0] HoldRepeatRst = 16'd100;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] click_gap_ms;
    logic [CfgW-1:0] hold_start_ms;
    logic [CfgW-1:0] hold_repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic [KeyW-1:0]  key_index;
    logic             raw_pressed;
    logic [TimeW-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic             raw_prev;
    logic             stable_level;
    logic [TimeW-1:0] change_time;
    logic [TimeW-1:0] press_time;
    logic [TimeW-1:0] release_time;
    logic [TimeW-1:0] repeat_time;
    logic [CntW-1:0]  click_counter;
    logic             long_reported;
  } key_state_t;

  typedef struct packed {
    logic [KeyW-1:0] key_id;
    logic            pressed;
    logic            press_event;
    logic            release_event;
    logic            long_press_event;
    logic            hold_repeat_event;
    logic            single_click_event;
    logic            multi_click_event;
    logic [CntW-1:0] click_total;
  } result_t;

endpackage

>>> rtl/kchd_cfg_regs.sv
// Timing configuration registers of the key click and hold detector.
module kchd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kchd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kchd_pkg::CfgW-1:0]     cfg_data_i,
  output kchd_pkg::cfg_t                cfg_o
);
  import kchd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE:    cfg_d.debounce_ms    = cfg_data_i;
        REG_LONG_PRESS:  cfg_d.long_press_ms  = cfg_data_i;
        REG_CLICK_GAP:   cfg_d.click_gap_ms   = cfg_data_i;
        REG_HOLD_START:  cfg_d.hold_start_ms  = cfg_data_i;
        REG_HOLD_REPEAT: cfg_d.hold_repeat_ms = cfg_data_i;
        default:         cfg_d = cfg_q;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms    <= DebounceRst;
      cfg_q.long_press_ms  <= LongPressRst;
      cfg_q.click_gap_ms   <= ClickGapRst;
      cfg_q.hold_start_ms  <= HoldStartRst;
      cfg_q.hold_repeat_ms <= HoldRepeatRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/kchd_key_state.sv
// Per-key state registers with one read and one write port.
module kchd_key_state (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [kchd_pkg::KeyIdxW-1:0]  rd_idx_i,
  output kchd_pkg::key_state_t          rd_state_o,
  input  logic                          wr_en_i,
  input  logic [kchd_pkg::KeyIdxW-1:0]  wr_idx_i,
  input  kchd_pkg::key_state_t          wr_state_i
);
  import kchd_pkg::*;

  key_state_t state_q [NumKeys];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumKeys; k++) begin
        state_q[k] <= '0;
      end
    end else if (wr_en_i) begin
      state_q[wr_idx_i] <= wr_state_i;
    end
  end

  assign rd_state_o = state_q[rd_idx_i];

endmodule

>>> rtl/kchd_eval.sv
// Single-pass evaluation of one key sample: debounce, long press, repeat, clicks.
module kchd_eval (
  input  kchd_pkg::sample_t     sample_i,
  input  kchd_pkg::cfg_t        cfg_i,
  input  kchd_pkg::key_state_t  state_i,
  output logic                  key_ok_o,
  output kchd_pkg::key_state_t  state_o,
  output kchd_pkg::result_t     result_o
);
  import kchd_pkg::*;

  logic [TimeW-1:0] now;
  logic             raw;
  logic             raw_chg;
  logic [TimeW-1:0] el_chg, el_press, el_rel, el_rep;
  logic             deb, press, release_w, hold_act;
  logic             lp, hr, gap_done;

  assign now      = sample_i.now_ms;
  assign raw      = sample_i.raw_pressed;
  assign key_ok_o = ({1'b0, sample_i.key_index} < (KeyW + 1)'(NumKeys));

  // All elapsed times come from the old state; a field written this step
  // would read as zero elapsed, which no strict compare can pass.
  assign raw_chg  = (raw != state_i.raw_prev);
  assign el_chg   = now - state_i.change_time;
  assign el_press = now - state_i.press_time;
  assign el_rel   = now - state_i.release_time;
  assign el_rep   = now - state_i.repeat_time;

  assign deb       = !raw_chg && (el_chg > {16'd0, cfg_i.debounce_ms})
                     && (raw != state_i.stable_level);
  assign press     = deb && raw;
  assign release_w = deb && !raw;
  assign hold_act  = state_i.stable_level && !deb;

  assign lp = hold_act && (el_press > {16'd0, cfg_i.long_press_ms})
              && !state_i.long_reported;
  assign hr = hold_act && (el_press > {16'd0, cfg_i.hold_start_ms})
              && (el_rep > {16'd0, cfg_i.hold_repeat_ms});
  assign gap_done = !release_w && (state_i.click_counter != '0)
                    && (el_rel > {16'd0, cfg_i.click_gap_ms});

  always_comb begin
    state_o          = state_i;
    state_o.raw_prev = raw;
    if (raw_chg) begin
      state_o.change_time = now;
    end
    if (deb) begin
      state_o.stable_level = raw;
    end
    if (press) begin
      state_o.press_time  = now;
      state_o.repeat_time = '0;
    end
    if (release_w) begin
      state_o.release_time  = now;
      state_o.long_reported = 1'b0;
      if ((el_press < {16'd0, cfg_i.long_press_ms}) &&
          (state_i.click_counter < ClickMax)) begin
        state_o.click_counter = state_i.click_counter + 1'b1;
      end
    end
    if (lp) begin
      state_o.long_reported = 1'b1;
    end
    if (hr) begin
      state_o.repeat_time = now;
    end
    if (gap_done) begin
      state_o.click_counter = '0;
    end
  end

  always_comb begin
    result_o        = '0;
    result_o.key_id = sample_i.key_index;
    if (key_ok_o) begin
      result_o.pressed            = deb ? raw : state_i.stable_level;
      result_o.press_event        = press;
      result_o.release_event      = release_w;
      result_o.long_press_event   = lp;
      result_o.hold_repeat_event  = hr;
      result_o.single_click_event = gap_done && (state_i.click_counter == 4'd1);
      result_o.multi_click_event  = gap_done && (state_i.click_counter != 4'd1);
      result_o.click_total        = gap_done ? state_i.click_counter : '0;
    end
  end

endmodule

>>> rtl/key_click_hold_detector_unit.sv
// Top level of the key click and hold detector.
// Usage:
//   Input stream: one word per key sample (key index, raw level, time in ms).
//   Output stream: exactly one word per sample with the debounced level and
//   press, release, long-press, hold-repeat and click events of that key.
//   Unused indexes are ignored. The user must write the timing registers through
//   cfg_we_i/cfg_idx_i/cfg_data_i only while no sample is in flight (not enforced).
// Stages: two register stages, the input register, then the result register.
// Throughput: one word per cycle while m_axis_tready is high. Per-key state is
//   read, updated and written back in the same cycle the result register loads, so
//   consecutive samples of the same key need no forwarding.
// Reset: all key state clears to zero, timing registers return to their
//   defaults, both stages empty.
// Stall: when m_axis_tready is low the result register holds; the input
//   register still takes one more word, and then tready drops until the
//   output drains.
module key_click_hold_detector_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // s_axis_tdata: key_index[2:0], raw_pressed[3], now_ms[35:4], zero fill
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [kchd_pkg::InDataW-1:0]    s_axis_tdata,
  // m_axis_tdata: key_id[2:0], pressed[3], press_event[4], release_event[5],
  // long_press_event[6], hold_repeat_event[7], single_click_event[8],
  // multi_click_event[9], click_total[13:10], zero fill
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [kchd_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [kchd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [kchd_pkg::CfgW-1:0]       cfg_data_i
);
  import kchd_pkg::*;

  `include "assert_macros.svh"

  logic       in_valid_q;
  sample_t    in_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       advance;
  logic       s_accept;
  cfg_t       cfg;
  key_state_t cur_state, nxt_state;
  result_t    result;
  logic       key_ok;

  // Move the held sample into the result stage when that stage is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q.key_index   <= s_axis_tdata[2:0];
      in_q.raw_pressed <= s_axis_tdata[3];
      in_q.now_ms      <= s_axis_tdata[35:4];
    end
  end

  kchd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  kchd_key_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (in_q.key_index[KeyIdxW-1:0]),
    .rd_state_o (cur_state),
    .wr_en_i    (advance && key_ok),
    .wr_idx_i   (in_q.key_index[KeyIdxW-1:0]),
    .wr_state_i (nxt_state)
  );

  kchd_eval u_eval (
    .sample_i (in_q),
    .cfg_i    (cfg),
    .state_i  (cur_state),
    .key_ok_o (key_ok),
    .state_o  (nxt_state),
    .result_o (result)
  );

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.click_total, out_q.multi_click_event,
                          out_q.single_click_event, out_q.hold_repeat_event,
                          out_q.long_press_event, out_q.release_event,
                          out_q.press_event, out_q.pressed, out_q.key_id};

  `ASSERT_IMPLIES(a_click_kind_excl, clk_i, rst_ni, out_valid_q,
                  !(out_q.single_click_event && out_q.multi_click_event))
  `ASSERT_IMPLIES(a_click_total_tag, clk_i, rst_ni, out_valid_q,
                  ((out_q.click_total != '0) ==
                   (out_q.single_click_event || out_q.multi_click_event)))
  `ASSERT_IMPLIES(a_edge_level, clk_i, rst_ni, out_valid_q,
                  (!out_q.press_event || out_q.pressed) &&
                  (!out_q.release_event || !out_q.pressed))
  `ASSERT_NEXT(a_advance_fills, clk_i, rst_ni, advance, out_valid_q)

endmodule
